@@ sv/at_command_line_parser_core_defines.svh @@
// Assertion helpers shared by the parser modules.
`ifndef AT_COMMAND_LINE_PARSER_CORE_DEFINES_SVH
`define AT_COMMAND_LINE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATCLP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ATCLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/atclp_pkg.sv @@
package atclp_pkg;

    localparam int LINE_MAX_DEF = 64;

    // result kinds
    localparam logic [2:0] KIND_SEND  = 3'd0;
    localparam logic [2:0] KIND_CSEND = 3'd1;
    localparam logic [2:0] KIND_SETID = 3'd2;
    localparam logic [2:0] KIND_SETRT = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // keyword slots in the match flags
    localparam int KW_SEND  = 0;
    localparam int KW_CSEND = 1;
    localparam int KW_SETID = 2;
    localparam int KW_SETRT = 3;
    localparam int KW_NUM   = 4;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [15:0] NUM_SAT = 16'hFFFF;
    localparam logic [15:0] ID_LIMIT = 16'd256;
    localparam int KW_BASE = 3;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  cmd_kind;
        logic [15:0] destination;
        logic        dest_valid;
        logic [7:0]  msg_byte;
        logic        msg_valid;
        logic        run_last;
        logic        truncated;
    } t_out_item;

    typedef struct packed {
        logic capture;     // take one byte of the line
        logic decide;      // parse the held line, latch the result header
        logic read;        // fetch the next message byte
        logic push;        // load a message result into the output register
        logic push_empty;  // load the single result of a line without message
    } t_dp_cmd;

    typedef struct packed {
        logic msg_empty;   // valid with decide
        logic msg_last;    // fetched byte is the final one
        logic out_free;    // output register can take a result
    } t_dp_stat;

    // "AT+"
    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = 8'h41;
            2'd1:    ch = 8'h54;
            default: ch = 8'h2B;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kw);
        return (kw == 2'(KW_SEND)) ? 3'd4 : 3'd5;
    endfunction

    // SEND, CSEND, SETID, SETRT
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
        logic [39:0] word;
        logic [7:0]  ch;
        unique case (kw)
            2'(KW_SEND):  word = 40'h53454E4400;
            2'(KW_CSEND): word = 40'h4353454E44;
            2'(KW_SETID): word = 40'h5345544944;
            default:      word = 40'h5345545254;
        endcase
        unique case (pos)
            3'd0:    ch = word[39:32];
            3'd1:    ch = word[31:24];
            3'd2:    ch = word[23:16];
            3'd3:    ch = word[15:8];
            default: ch = word[7:0];
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    // acc*10 + digit, saturating
    function automatic logic [15:0] dec_step(input logic [15:0] acc, input logic [7:0] ch);
        logic [7:0]  dig;
        logic [19:0] t;
        dig = ch - CH_0;
        t = 20'(acc) * 20'd10 + 20'(dig[3:0]);
        return (t > 20'(NUM_SAT)) ? NUM_SAT : t[15:0];
    endfunction

endpackage

@@ sv/at_command_line_parser_core.sv @@
// Channel   Direction  Valid        Stall        Payload
// input     in         i_in_valid   o_in_stall   i_in_data  (char_in, end_of_line)
// output    out        o_out_valid  i_out_stall  o_out_data (kind, dest, msg byte, flags)
//
// A byte that does not end the line is taken even while a result may still wait.
// The final byte is followed by a parse step, then a line buffer read and an output register
// load for each message byte; a line without message gives 1 result.
// The buffer read is registered and not overlapped with the output load.
// Reset is synchronous, active low; the line buffer itself is not cleared.
// Output stall holds the result register and pauses emission; input stays stalled until
// the last result of the line is loaded.
module at_command_line_parser_core #(
    parameter int LINE_MAX = atclp_pkg::LINE_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  atclp_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output atclp_pkg::t_out_item o_out_data
);

    atclp_pkg::t_dp_cmd  dp_cmd;
    atclp_pkg::t_dp_stat dp_stat;

    atclp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_eol   (i_in_data.end_of_line),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    atclp_dp #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/atclp_ctrl.sv @@
`include "at_command_line_parser_core_defines.svh"

module atclp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_eol,
    output logic                o_in_stall,
    input  atclp_pkg::t_dp_stat i_stat,
    output atclp_pkg::t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_PUSH   = 3'd3;
    localparam logic [2:0] S_EMPTY  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = in_accept;
                if (in_accept && i_in_eol) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_stat.msg_empty ? S_EMPTY : S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state = i_stat.msg_last ? S_IDLE : S_READ;
                end
            end
            S_EMPTY: begin
                if (i_stat.out_free) begin
                    o_cmd.push_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ATCLP_ASSERT_SAME(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.capture, o_cmd.decide, o_cmd.read, o_cmd.push, o_cmd.push_empty}), "controller issued two commands at once")
    `ATCLP_ASSERT_SAME(a_push_free, i_clk, i_rst_n, o_cmd.push || o_cmd.push_empty, i_stat.out_free, "result pushed into a full output register")
    `ATCLP_ASSERT_NEXT(a_eol_decide, i_clk, i_rst_n, in_accept && i_in_eol, o_cmd.decide, "final byte not followed by parse")

endmodule

@@ sv/atclp_dp.sv @@
`include "at_command_line_parser_core_defines.svh"

module atclp_dp #(
    parameter int LINE_MAX = atclp_pkg::LINE_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atclp_pkg::t_dp_cmd   i_cmd,
    input  atclp_pkg::t_in_item  i_in_data,
    input  logic                 i_out_stall,
    output atclp_pkg::t_dp_stat  o_stat,
    output logic                 o_out_valid,
    output atclp_pkg::t_out_item o_out_data
);

    localparam int LEN_W  = $clog2(LINE_MAX + 1);
    localparam int ADDR_W = $clog2(LINE_MAX);

    logic [7:0] mem [LINE_MAX];
    logic [7:0] r_rd_data;

    // line scan state
    logic [LEN_W-1:0]            r_len, n_len;
    logic                        r_ovf, n_ovf;
    logic                        r_eq_seen, n_eq_seen;
    logic [LEN_W-1:0]            r_eq_idx, n_eq_idx;
    logic                        r_comma_seen, n_comma_seen;
    logic [LEN_W-1:0]            r_comma_idx, n_comma_idx;
    logic                        r_comma_after_eq, n_comma_after_eq;
    logic                        r_prefix_ok, n_prefix_ok;
    logic [atclp_pkg::KW_NUM-1:0] r_kw_ok, n_kw_ok;
    logic [15:0]                 r_dest_acc, n_dest_acc;
    logic                        r_dest_ok, n_dest_ok;
    logic [15:0]                 r_id_acc, n_id_acc;
    logic                        r_id_ok, n_id_ok;

    // latched result header and message range
    logic [2:0]       r_kind;
    logic [15:0]      r_dest;
    logic             r_dv;
    logic             r_trunc;
    logic [LEN_W-1:0] r_ptr;
    logic [LEN_W-1:0] r_end;

    logic                  r_out_valid;
    atclp_pkg::t_out_item  r_out;

    logic [7:0]       ch;
    logic             store;
    logic [LEN_W-1:0] kw_off;
    logic [2:0]       kw_pos;

    logic [2:0]       d_kind;
    logic [15:0]      d_dest;
    logic             d_dv;
    logic [LEN_W-1:0] d_from;
    logic [LEN_W-1:0] d_to;
    logic             d_base_ok;

    assign ch     = i_in_data.char_in;
    assign store  = i_cmd.capture && (r_len < LEN_W'(LINE_MAX));
    assign kw_off = r_len - LEN_W'(atclp_pkg::KW_BASE);
    assign kw_pos = kw_off[2:0];

    always_comb begin
        n_len            = r_len;
        n_ovf            = r_ovf;
        n_eq_seen        = r_eq_seen;
        n_eq_idx         = r_eq_idx;
        n_comma_seen     = r_comma_seen;
        n_comma_idx      = r_comma_idx;
        n_comma_after_eq = r_comma_after_eq;
        n_prefix_ok      = r_prefix_ok;
        n_kw_ok          = r_kw_ok;
        n_dest_acc       = r_dest_acc;
        n_dest_ok        = r_dest_ok;
        n_id_acc         = r_id_acc;
        n_id_ok          = r_id_ok;
        if (i_cmd.decide) begin
            n_len            = '0;
            n_ovf            = 1'b0;
            n_eq_seen        = 1'b0;
            n_eq_idx         = '0;
            n_comma_seen     = 1'b0;
            n_comma_idx      = '0;
            n_comma_after_eq = 1'b0;
            n_prefix_ok      = 1'b1;
            n_kw_ok          = '1;
            n_dest_acc       = '0;
            n_dest_ok        = 1'b1;
            n_id_acc         = '0;
            n_id_ok          = 1'b1;
        end else if (i_cmd.capture && !store) begin
            n_ovf = 1'b1;
        end else if (store) begin
            n_len = r_len + LEN_W'(1);
            if (ch == atclp_pkg::CH_EQUALS && !r_eq_seen) begin
                n_eq_seen = 1'b1;
                n_eq_idx  = r_len;
            end
            if (ch == atclp_pkg::CH_COMMA && !r_comma_seen) begin
                n_comma_seen     = 1'b1;
                n_comma_idx      = r_len;
                n_comma_after_eq = r_eq_seen;
            end
            if (r_len < LEN_W'(atclp_pkg::KW_BASE) &&
                ch != atclp_pkg::prefix_char(r_len[1:0])) begin
                n_prefix_ok = 1'b0;
            end
            // a '=' inside the keyword span mismatches every keyword letter
            for (int k = 0; k < atclp_pkg::KW_NUM; k++) begin
                if (r_len >= LEN_W'(atclp_pkg::KW_BASE) &&
                    kw_off < LEN_W'(atclp_pkg::kw_len(2'(k))) &&
                    ch != atclp_pkg::kw_char(2'(k), kw_pos)) begin
                    n_kw_ok[k] = 1'b0;
                end
            end
            // destination: between '=' and the first comma
            if (r_eq_seen && !r_comma_seen && ch != atclp_pkg::CH_COMMA) begin
                if (atclp_pkg::is_digit(ch)) begin
                    n_dest_acc = atclp_pkg::dec_step(r_dest_acc, ch);
                end else begin
                    n_dest_ok = 1'b0;
                end
            end
            // id: everything after '='
            if (r_eq_seen) begin
                if (atclp_pkg::is_digit(ch)) begin
                    n_id_acc = atclp_pkg::dec_step(r_id_acc, ch);
                end else begin
                    n_id_ok = 1'b0;
                end
            end
        end
    end

    // parse decision from the scan state
    always_comb begin
        d_kind    = atclp_pkg::KIND_ERROR;
        d_dest    = '0;
        d_dv      = 1'b0;
        d_from    = '0;
        d_to      = r_len;
        d_base_ok = r_prefix_ok && (r_len >= LEN_W'(4)) && r_eq_seen &&
                    (r_eq_idx >= LEN_W'(atclp_pkg::KW_BASE));
        if (d_base_ok) begin
            priority if (r_kw_ok[atclp_pkg::KW_SEND] || r_kw_ok[atclp_pkg::KW_CSEND]) begin
                if (r_comma_after_eq && r_dest_ok) begin
                    d_kind = r_kw_ok[atclp_pkg::KW_SEND] ? atclp_pkg::KIND_SEND
                                                         : atclp_pkg::KIND_CSEND;
                    d_dest = r_dest_acc;
                    d_dv   = 1'b1;
                    d_from = r_comma_idx + LEN_W'(1);
                end
            end else if (r_kw_ok[atclp_pkg::KW_SETID]) begin
                if (r_id_ok) begin
                    d_kind = atclp_pkg::KIND_SETID;
                    if (r_id_acc < atclp_pkg::ID_LIMIT) begin
                        d_dest = r_id_acc;
                        d_dv   = 1'b1;
                    end
                end
            end else if (r_kw_ok[atclp_pkg::KW_SETRT]) begin
                d_kind = atclp_pkg::KIND_SETRT;
                d_from = r_len;
            end else begin
                d_kind = atclp_pkg::KIND_ERROR;
            end
        end
        // kinds without a message get an empty range
        if (d_kind == atclp_pkg::KIND_SETID) begin
            d_from = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            mem[r_len[ADDR_W-1:0]] <= ch;
        end
        if (i_cmd.read) begin
            r_rd_data <= mem[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len            <= '0;
            r_ovf            <= 1'b0;
            r_eq_seen        <= 1'b0;
            r_eq_idx         <= '0;
            r_comma_seen     <= 1'b0;
            r_comma_idx      <= '0;
            r_comma_after_eq <= 1'b0;
            r_prefix_ok      <= 1'b1;
            r_kw_ok          <= '1;
            r_dest_acc       <= '0;
            r_dest_ok        <= 1'b1;
            r_id_acc         <= '0;
            r_id_ok          <= 1'b1;
            r_ptr            <= '0;
            r_end            <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_len            <= n_len;
            r_ovf            <= n_ovf;
            r_eq_seen        <= n_eq_seen;
            r_eq_idx         <= n_eq_idx;
            r_comma_seen     <= n_comma_seen;
            r_comma_idx      <= n_comma_idx;
            r_comma_after_eq <= n_comma_after_eq;
            r_prefix_ok      <= n_prefix_ok;
            r_kw_ok          <= n_kw_ok;
            r_dest_acc       <= n_dest_acc;
            r_dest_ok        <= n_dest_ok;
            r_id_acc         <= n_id_acc;
            r_id_ok          <= n_id_ok;
            if (i_cmd.decide) begin
                r_ptr <= d_from;
                r_end <= d_to;
            end else if (i_cmd.read) begin
                r_ptr <= r_ptr + LEN_W'(1);
            end
            if (i_cmd.push || i_cmd.push_empty) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // header and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_kind  <= d_kind;
            r_dest  <= d_dest;
            r_dv    <= d_dv;
            r_trunc <= r_ovf;
        end
        if (i_cmd.push || i_cmd.push_empty) begin
            r_out.cmd_kind    <= r_kind;
            r_out.destination <= r_dest;
            r_out.dest_valid  <= r_dv;
            r_out.msg_byte    <= i_cmd.push ? r_rd_data : 8'h00;
            r_out.msg_valid   <= i_cmd.push;
            r_out.run_last    <= i_cmd.push_empty || (r_ptr == r_end);
            r_out.truncated   <= r_trunc;
        end
    end

    assign o_stat.msg_empty = (d_from >= d_to);
    assign o_stat.msg_last  = (r_ptr == r_end);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

    `ATCLP_ASSERT_SAME(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(LINE_MAX), "line length beyond buffer")
    `ATCLP_ASSERT_SAME(a_read_range, i_clk, i_rst_n, i_cmd.read, r_ptr < r_end, "message fetch outside the held line")
    `ATCLP_ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, i_cmd.decide, r_len == '0 && !r_eq_seen && !r_ovf, "line state not cleared after parse")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_PERIOD   = 2;
    localparam int BUF_BYTES     = atclp_pkg::LINE_MAX_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;

    typedef logic [7:0] t_byte_q[$];

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    atclp_pkg::t_in_item  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    atclp_pkg::t_out_item o_out_data;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;
    int bytes_sent = 0;
    int lines_sent = 0;
    int results_seen = 0;
    int truncated_lines = 0;
    int kind_count[5] = '{default: 0};

    // line as the parser holds it
    logic [7:0]           held_bytes[BUF_BYTES];
    int                   held_len = 0;
    int                   equals_mark = 0;    // first '=' index plus one, 0 for none
    int                   comma_mark = 0;     // first ',' index plus one, 0 for none
    bit                   held_overflow = 1'b0;
    atclp_pkg::t_out_item parsed_results_q[$];

    at_command_line_parser_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    function automatic bit keyword_matches(string kw, int kw_room);
        if (kw_room < kw.len()) return 1'b0;
        for (int k = 0; k < kw.len(); k++) begin
            if (held_bytes[atclp_pkg::KW_BASE + k] != kw[k]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // decimal digits in [first_idx, upto), saturating; 0 on a non-digit
    function automatic bit decimal_value(int first_idx, int upto, output int value);
        int acc;
        acc = 0;
        for (int k = first_idx; k < upto; k++) begin
            if (held_bytes[k] < atclp_pkg::CH_0 || held_bytes[k] > atclp_pkg::CH_9) return 1'b0;
            acc = acc * 10 + int'(held_bytes[k] - atclp_pkg::CH_0);
            if (acc > int'(atclp_pkg::NUM_SAT)) acc = int'(atclp_pkg::NUM_SAT);
        end
        value = acc;
        return 1'b1;
    endfunction

    function automatic void parse_held_line();
        logic [2:0]           kind;
        int                   dest, val, eqi, kw_room, msg_first, msg_end;
        bit                   dest_ok;
        atclp_pkg::t_out_item res;
        kind = atclp_pkg::KIND_ERROR;
        dest = 0;
        dest_ok = 1'b0;
        msg_first = 0;
        msg_end = 0;
        if (held_len >= 4 && held_bytes[0] == "A" && held_bytes[1] == "T"
                && held_bytes[2] == "+" && equals_mark > atclp_pkg::KW_BASE) begin
            eqi = equals_mark - 1;
            kw_room = eqi - atclp_pkg::KW_BASE;
            if (keyword_matches("SEND", kw_room) || keyword_matches("CSEND", kw_room)) begin
                // comma must follow the '='; a leading comma counts as none
                if (comma_mark > equals_mark && decimal_value(eqi + 1, comma_mark - 1, val)) begin
                    kind = keyword_matches("SEND", kw_room) ? atclp_pkg::KIND_SEND
                                                            : atclp_pkg::KIND_CSEND;
                    dest = val;
                    dest_ok = 1'b1;
                    msg_first = comma_mark;
                    msg_end = held_len;
                end
            end else if (keyword_matches("SETID", kw_room)) begin
                if (decimal_value(eqi + 1, held_len, val)) begin
                    kind = atclp_pkg::KIND_SETID;
                    if (val < int'(atclp_pkg::ID_LIMIT)) begin
                        dest = val;
                        dest_ok = 1'b1;
                    end
                end
            end else if (keyword_matches("SETRT", kw_room)) begin
                kind = atclp_pkg::KIND_SETRT;
            end
        end
        if (kind == atclp_pkg::KIND_ERROR) begin
            msg_first = 0;
            msg_end = held_len;
        end
        res.cmd_kind = kind;
        res.destination = 16'(dest);
        res.dest_valid = dest_ok;
        res.truncated = held_overflow;
        if (msg_end > msg_first) begin
            for (int k = msg_first; k < msg_end; k++) begin
                res.msg_byte = held_bytes[k];
                res.msg_valid = 1'b1;
                res.run_last = (k == msg_end - 1);
                parsed_results_q.push_back(res);
            end
        end else begin
            res.msg_byte = '0;
            res.msg_valid = 1'b0;
            res.run_last = 1'b1;
            parsed_results_q.push_back(res);
        end
        kind_count[kind]++;
        if (held_overflow) truncated_lines++;
    endfunction

    function automatic void take_line_byte(atclp_pkg::t_in_item item);
        if (held_len < BUF_BYTES) begin
            held_bytes[held_len] = item.char_in;
            if (item.char_in == atclp_pkg::CH_EQUALS && equals_mark == 0) begin
                equals_mark = held_len + 1;
            end
            if (item.char_in == atclp_pkg::CH_COMMA && comma_mark == 0) begin
                comma_mark = held_len + 1;
            end
            held_len++;
        end else begin
            held_overflow = 1'b1;
        end
        if (item.end_of_line) begin
            parse_held_line();
            held_len = 0;
            equals_mark = 0;
            comma_mark = 0;
            held_overflow = 1'b0;
            lines_sent++;
        end
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        atclp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (parsed_results_q.size() == 0) begin
                $error("result with nothing outstanding: kind %0d byte %0h",
                       o_out_data.cmd_kind, o_out_data.msg_byte);
                error_count++;
            end else begin
                want = parsed_results_q.pop_front();
                check_field("cmd_kind", 16'(want.cmd_kind), 16'(o_out_data.cmd_kind));
                check_field("destination", want.destination, o_out_data.destination);
                check_field("dest_valid", 16'(want.dest_valid), 16'(o_out_data.dest_valid));
                check_field("msg_byte", 16'(want.msg_byte), 16'(o_out_data.msg_byte));
                check_field("msg_valid", 16'(want.msg_valid), 16'(o_out_data.msg_valid));
                check_field("run_last", 16'(want.run_last), 16'(o_out_data.run_last));
                check_field("truncated", 16'(want.truncated), 16'(o_out_data.truncated));
            end
        end
    end

    // one input transfer; valid is held until the byte is taken
    task automatic send_item(logic [7:0] ch, logic eol);
        atclp_pkg::t_in_item item;
        item.char_in = ch;
        item.end_of_line = eol;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        take_line_byte(item);
        bytes_sent++;
    endtask

    task automatic send_line(input t_byte_q line);
        foreach (line[k]) send_item(line[k], k == line.size() - 1);
    endtask

    task automatic append_text(ref t_byte_q line, input string s);
        for (int k = 0; k < s.len(); k++) line.push_back(s[k]);
    endtask

    task automatic send_text(string s);
        t_byte_q line;
        line = {};
        append_text(line, s);
        send_line(line);
    endtask

    task automatic wait_all_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (parsed_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (parsed_results_q.size() != 0) begin
            $error("%0d results never arrived", parsed_results_q.size());
            error_count++;
            parsed_results_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_send_lines();
        send_text("AT+SEND=123,hi");
        send_text("AT+CSEND=99999,Z");
        send_text("AT+SEND=,m");
        send_text("AT+SEND=7,");
        send_text("AT+SENDX=3,k");
        wait_all_results();
    endtask

    task automatic test_setid_setrt_lines();
        send_text("AT+SETID=255");
        send_text("AT+SETID=256");
        send_text("AT+SETID=");
        send_text("AT+SETID=1a");
        send_text("AT+SETRT=abc");
        wait_all_results();
    endtask

    task automatic test_malformed_lines();
        send_text("A");
        send_text("AT+");
        send_text("XT+SEND=1,a");
        send_text("AT+SEND,1=2,x");
        send_text("AT+SEND=12");
        send_text("AT+SEND=1x,a");
        send_text("AT+=5");
        send_text("AT=SEND");
        send_text("AT+SEN=1,a");
        wait_all_results();
    endtask

    task automatic test_long_lines();
        t_byte_q line;
        // exactly full, no truncation
        line = {};
        append_text(line, "AT+SEND=5,");
        while (line.size() < BUF_BYTES) line.push_back(8'($urandom_range(0, 255)));
        send_line(line);
        // overflow on a good command, the final two bytes dropped
        line = {};
        append_text(line, "AT+CSEND=42,");
        while (line.size() < BUF_BYTES + 2) line.push_back(8'($urandom_range(0, 255)));
        send_line(line);
        wait_all_results();
    endtask

    task automatic build_random_line(output t_byte_q line);
        int pick, kw, n;
        line = {};
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            repeat ($urandom_range(1, 10)) line.push_back(8'($urandom_range(0, 255)));
            return;
        end
        kw = $urandom_range(0, atclp_pkg::KW_NUM - 1);
        append_text(line, "AT+");
        case (kw)
            atclp_pkg::KW_SEND:  append_text(line, "SEND");
            atclp_pkg::KW_CSEND: append_text(line, "CSEND");
            atclp_pkg::KW_SETID: append_text(line, "SETID");
            default:             append_text(line, "SETRT");
        endcase
        if ($urandom_range(0, 9) == 0) line.push_back("A" + 8'($urandom_range(0, 25)));
        line.push_back(atclp_pkg::CH_EQUALS);
        if (kw == atclp_pkg::KW_SEND || kw == atclp_pkg::KW_CSEND) begin
            repeat ($urandom_range(0, 6)) begin
                line.push_back(atclp_pkg::CH_0 + 8'($urandom_range(0, 9)));
            end
            line.push_back(atclp_pkg::CH_COMMA);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
            repeat (n) line.push_back(8'($urandom_range(0, 255)));
        end else if (kw == atclp_pkg::KW_SETID) begin
            repeat ($urandom_range(0, 4)) begin
                line.push_back(atclp_pkg::CH_0 + 8'($urandom_range(0, 9)));
            end
        end else begin
            repeat ($urandom_range(0, 6)) line.push_back(8'($urandom_range(0, 255)));
        end
        // broken variant: one byte replaced, often by a delimiter or digit
        if (pick >= 65) begin
            n = $urandom_range(0, line.size() - 1);
            case ($urandom_range(0, 3))
                0:       line[n] = atclp_pkg::CH_EQUALS;
                1:       line[n] = atclp_pkg::CH_COMMA;
                2:       line[n] = atclp_pkg::CH_0 + 8'($urandom_range(0, 9));
                default: line[n] = 8'($urandom_range(0, 255));
            endcase
        end
    endtask

    task automatic test_random_lines(int byte_budget);
        t_byte_q line;
        int      start;
        start = bytes_sent;
        while (bytes_sent - start < byte_budget) begin
            build_random_line(line);
            send_line(line);
            if ($urandom_range(0, 9) == 0) wait_all_results();
        end
        wait_all_results();
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 7;
        rx_idle_pct = 49;
        test_send_lines();
        test_setid_setrt_lines();
        test_malformed_lines();

        tx_idle_pct = 49;
        rx_idle_pct = 7;
        test_long_lines();
        test_random_lines(20);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_lines(20);

        $display("Parsed %0d lines from %0d bytes, %0d results checked, %0d lines truncated.",
                 lines_sent, bytes_sent, results_seen, truncated_lines);
        $display("Kinds: send %0d, csend %0d, set id %0d, set route %0d, error %0d.",
                 kind_count[atclp_pkg::KIND_SEND], kind_count[atclp_pkg::KIND_CSEND],
                 kind_count[atclp_pkg::KIND_SETID], kind_count[atclp_pkg::KIND_SETRT],
                 kind_count[atclp_pkg::KIND_ERROR]);
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
